// ===== rtl/sdr_pkg.sv =====
`default_nettype none

package sdr_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 8;

    // Search word that walks down the cell chain, one cell per cycle while the chain is not stalled
    typedef struct packed {
        logic                      valid;
        logic                      clear;
        logic                      found;
        logic                      done;
        logic [POS_W-1:0]          pos;
        logic signed [VALUE_W-1:0] value;
    } sdr_token_t;

endpackage

`default_nettype wire

// ===== rtl/sdr_cell.sv =====
`default_nettype none

module sdr_cell #(
    parameter int INDEX = 0
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire sdr_pkg::sdr_token_t tok_in,
    output sdr_pkg::sdr_token_t     tok_out
);

    logic                               valid_reg;
    logic                               valid_next;
    logic signed [sdr_pkg::VALUE_W-1:0] entry_reg;
    logic                               entry_we;
    sdr_pkg::sdr_token_t                tok_reg;
    sdr_pkg::sdr_token_t                tok_next;
    logic                               hit;
    logic                               empty;

    assign hit   = valid_reg && (entry_reg == tok_in.value);
    assign empty = !valid_reg || tok_in.clear;

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        entry_we   = 1'b0;
        if (tok_in.valid)
        begin
            if (tok_in.clear && tok_in.done)
            begin
                // drop everything behind the first entry of a new set
                valid_next = 1'b0;
            end
            else if (!tok_in.done && !tok_in.found)
            begin
                if (empty)
                begin
                    entry_we      = 1'b1;
                    valid_next    = 1'b1;
                    tok_next.done = 1'b1;
                    tok_next.pos  = sdr_pkg::POS_W'(INDEX);
                end
                else if (hit)
                begin
                    tok_next.found = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && entry_we)
        begin
            entry_reg <= tok_in.value;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

// ===== rtl/stream_duplicate_remover_top.sv =====
// Path: an accepted word passes through DEPTH cells and then one output register to result_valid,
// the first cell being loaded at the accepting edge.
// Throughput: one word per cycle; the whole cell chain advances together and holds
// only while a result sits in the output register under stall.
// Reset (rst_n, asynchronous, active low) empties every cell and the output register.
`default_nettype none

module stream_duplicate_remover_top #(
    parameter int DEPTH = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               item_valid,
    output logic                                    item_stall,
    input  wire logic signed [sdr_pkg::VALUE_W-1:0] value,
    input  wire logic                               start_set,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic signed [sdr_pkg::VALUE_W-1:0]      distinct_value,
    output logic [sdr_pkg::POS_W-1:0]               position,
    output logic                                    overflow
);

    sdr_pkg::sdr_token_t                tok [DEPTH+1];
    logic                               advance;
    logic                               res_hit;
    logic                               result_valid_reg;
    logic signed [sdr_pkg::VALUE_W-1:0] value_reg;
    logic [sdr_pkg::POS_W-1:0]          pos_reg;
    logic [sdr_pkg::POS_W-1:0]          pos_next;
    logic                               ovf_reg;

    assign advance    = !result_valid_reg || !result_stall;
    assign item_stall = !advance;

    assign tok[0] = '{valid: item_valid, clear: start_set, found: 1'b0, done: 1'b0,
                      pos: '0, value: value};

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sdr_cell #(
            .INDEX(i)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .advance(advance),
            .tok_in (tok[i]),
            .tok_out(tok[i+1])
        );
    end

    assign res_hit  = tok[DEPTH].valid && !tok[DEPTH].found;
    assign pos_next = tok[DEPTH].done ? tok[DEPTH].pos : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= res_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            value_reg <= tok[DEPTH].value;
            pos_reg   <= pos_next;
            ovf_reg   <= !tok[DEPTH].done;
        end
    end

    assign result_valid   = result_valid_reg;
    assign distinct_value = value_reg;
    assign position       = pos_reg;
    assign overflow       = ovf_reg;

endmodule

`default_nettype wire

// ===== rtl/sdr_checker.sv =====
`default_nettype none

module sdr_checker #(
    parameter int DEPTH = 16
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               item_valid,
    input wire logic                               item_stall,
    input wire logic signed [sdr_pkg::VALUE_W-1:0] value,
    input wire logic                               start_set,
    input wire logic                               result_valid,
    input wire logic                               result_stall,
    input wire logic signed [sdr_pkg::VALUE_W-1:0] distinct_value,
    input wire logic [sdr_pkg::POS_W-1:0]          position,
    input wire logic                               overflow
);

    // input held back only while a result is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("input stalled without a blocked result");

    a_ovf_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && overflow) |-> (position == '0))
        else $error("overflow result with nonzero position");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !overflow) |-> (32'(position) < DEPTH))
        else $error("position beyond table depth");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=>
            (result_valid && $stable(distinct_value) && $stable(position)
             && $stable(overflow)))
        else $error("stalled result changed");

    // hold a stalled input word until it is taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_stall) |=>
            (item_valid && $stable(value) && $stable(start_set)))
        else $error("stalled input word changed");

endmodule

bind stream_duplicate_remover_top sdr_checker #(
    .DEPTH(DEPTH)
) u_sdr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .value         (value),
    .start_set     (start_set),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .distinct_value(distinct_value),
    .position      (position),
    .overflow      (overflow)
);

`default_nettype wire
